// File: hdl/pidd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pidd_pkg;

  localparam int SETPOINT_W = 12;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 14;
  localparam int ILIM_W     = 15;
  localparam int DUTY_W     = 14;
  localparam int ISUM_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT       = 3'd0,
    REG_P_GAIN         = 3'd1,
    REG_I_GAIN         = 3'd2,
    REG_D_GAIN         = 3'd3,
    REG_BASE_SPEED     = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_DUTY_LIMIT     = 3'd6
  } cfg_reg_t;

  localparam logic [SETPOINT_W-1:0]    SETPOINT_RST   = 12'd180;
  localparam logic signed [GAIN_W-1:0] P_GAIN_RST     = 16'sd1664;
  localparam logic signed [GAIN_W-1:0] I_GAIN_RST     = 16'sd0;
  localparam logic signed [GAIN_W-1:0] D_GAIN_RST     = 16'sd44;
  localparam logic [SPEED_W-1:0]       BASE_SPEED_RST = 14'd700;
  localparam logic [ILIM_W-1:0]        ILIM_RST       = 15'd3000;
  localparam logic [DUTY_W-1:0]        DUTY_LIMIT_RST = 14'd1000;

  typedef struct packed {
    logic              reverse;
    logic [DUTY_W-1:0] duty;
  } drive_out_t;

endpackage

`default_nettype wire

// File: hdl/pid_differential_drive.sv
// an input passes the position, product and result registers on its way to out_valid
// throughput: one sample per cycle unless out_ready stalls; the integral and last error
// update as stage 1 passes a sample on; a stage waits while the next is full and blocked
// reset: synchronous active-low rst_n clears all valid flags, the integral and last error,
// and loads the registers with their default values
`timescale 1ns / 1ps
`default_nettype none

module pid_differential_drive
  import pidd_pkg::*;
#(
  parameter int SAMPLE_BITS    = 12,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_position,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [DUTY_W-1:0]           out_left_duty,
  output logic                        out_left_reverse,
  output logic [DUTY_W-1:0]           out_right_duty,
  output logic                        out_right_reverse,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int ERR_W  = ((SAMPLE_BITS > SETPOINT_W) ? SAMPLE_BITS : SETPOINT_W) + 1;
  localparam int RAW_W  = ((ERR_W > ISUM_W) ? ERR_W : ISUM_W) + 1;
  localparam int DIF_W  = ERR_W + 1;
  localparam int P_W    = GAIN_W + ERR_W;
  localparam int I_W    = GAIN_W + ISUM_W;
  localparam int D_W    = GAIN_W + DIF_W;
  localparam int MAXP_W = (D_W > I_W) ? D_W : I_W;
  localparam int ACC_W  = MAXP_W + 2;
  localparam int DRV_W  = ACC_W + 1;

  // configuration registers
  logic [SETPOINT_W-1:0]    setpoint_r;
  logic signed [GAIN_W-1:0] p_gain_r;
  logic signed [GAIN_W-1:0] i_gain_r;
  logic signed [GAIN_W-1:0] d_gain_r;
  logic [SPEED_W-1:0]       base_r;
  logic [ILIM_W-1:0]        ilim_r;
  logic [DUTY_W-1:0]        dlim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= SETPOINT_RST;
      p_gain_r   <= P_GAIN_RST;
      i_gain_r   <= I_GAIN_RST;
      d_gain_r   <= D_GAIN_RST;
      base_r     <= BASE_SPEED_RST;
      ilim_r     <= ILIM_RST;
      dlim_r     <= DUTY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SETPOINT:       setpoint_r <= cfg_data[SETPOINT_W-1:0];
        REG_P_GAIN:         p_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_I_GAIN:         i_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_D_GAIN:         d_gain_r   <= cfg_data[GAIN_W-1:0];
        REG_BASE_SPEED:     base_r     <= cfg_data[SPEED_W-1:0];
        REG_INTEGRAL_LIMIT: ilim_r     <= cfg_data[ILIM_W-1:0];
        REG_DUTY_LIMIT:     dlim_r     <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_go, s2_free, s1_go, in_fire;

  assign out_go   = !out_v_r || out_ready;
  assign s2_free  = !s2_v_r || out_go;
  assign s1_go    = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;
  assign in_fire  = in_valid && in_ready;

  assign s1_v_nxt  = in_fire || (s1_v_r && !s1_go);
  assign s2_v_nxt  = s1_go || (s2_v_r && !out_go);
  assign out_v_nxt = (s2_v_r && out_go) || (out_v_r && !out_ready);

  // stage 1: error, clamped integral, derivative, products
  logic [SAMPLE_BITS-1:0]   pos_r;
  logic signed [ISUM_W-1:0] esum_r, esum_nxt;
  logic signed [ERR_W-1:0]  prev_err_r;
  logic signed [ERR_W-1:0]  err;
  logic signed [RAW_W-1:0]  raw_sum, lim_pos, lim_neg, sum_sel;
  logic signed [DIF_W-1:0]  diff;
  logic signed [P_W-1:0]    p_prod, p_prod_r;
  logic signed [I_W-1:0]    i_prod, i_prod_r;
  logic signed [D_W-1:0]    d_prod, d_prod_r;

  assign err = signed'({{(ERR_W-SETPOINT_W){1'b0}}, setpoint_r}
                     - {{(ERR_W-SAMPLE_BITS){1'b0}}, pos_r});
  assign raw_sum = signed'({{(RAW_W-ERR_W){err[ERR_W-1]}}, err}
                         + {{(RAW_W-ISUM_W){esum_r[ISUM_W-1]}}, esum_r});
  assign lim_pos = signed'({{(RAW_W-ILIM_W){1'b0}}, ilim_r});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (raw_sum > lim_pos) begin
      sum_sel = lim_pos;
    end else if (raw_sum < lim_neg) begin
      sum_sel = lim_neg;
    end else begin
      sum_sel = raw_sum;
    end
  end

  // clamped sum always fits the stored width since the limit is below 2^15
  assign esum_nxt = sum_sel[ISUM_W-1:0];
  assign diff     = signed'({err[ERR_W-1], err} - {prev_err_r[ERR_W-1], prev_err_r});
  assign p_prod   = P_W'(p_gain_r) * P_W'(err);
  assign i_prod   = I_W'(i_gain_r) * I_W'(esum_nxt);
  assign d_prod   = D_W'(d_gain_r) * D_W'(diff);

  // stage 2: sum of terms, shift toward zero, drives
  logic signed [ACC_W-1:0] acc, corr_fl, corr;
  logic                    rnd;
  logic signed [DRV_W-1:0] base_ext, corr_ext, left_drv, right_drv;
  drive_out_t              left_res, right_res;

  assign acc = signed'({{(ACC_W-P_W){p_prod_r[P_W-1]}}, p_prod_r}
                     + {{(ACC_W-I_W){i_prod_r[I_W-1]}}, i_prod_r}
                     + {{(ACC_W-D_W){d_prod_r[D_W-1]}}, d_prod_r});
  assign corr_fl = acc >>> GAIN_FRAC_BITS;
  // arithmetic shift floors; bump negative values with dropped bits back toward zero
  assign rnd     = acc[ACC_W-1] && (|acc[GAIN_FRAC_BITS-1:0]);
  assign corr    = corr_fl + ACC_W'(rnd);

  assign base_ext  = signed'({{(DRV_W-SPEED_W){1'b0}}, base_r});
  assign corr_ext  = signed'({corr[ACC_W-1], corr});
  assign left_drv  = base_ext - corr_ext;
  assign right_drv = base_ext + corr_ext;

  pidd_drive #(.DRV_W(DRV_W)) u_left (
    .drive      (left_drv),
    .duty_limit (dlim_r),
    .result     (left_res)
  );

  pidd_drive #(.DRV_W(DRV_W)) u_right (
    .drive      (right_drv),
    .duty_limit (dlim_r),
    .result     (right_res)
  );

  drive_out_t left_r, right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      esum_r     <= '0;
      prev_err_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_go) begin
        esum_r     <= esum_nxt;
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_r <= in_position;
    end
    if (s1_go) begin
      p_prod_r <= p_prod;
      i_prod_r <= i_prod;
      d_prod_r <= d_prod;
    end
    if (s2_v_r && out_go) begin
      left_r  <= left_res;
      right_r <= right_res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_left_duty     = left_r.duty;
  assign out_left_reverse  = left_r.reverse;
  assign out_right_duty    = right_r.duty;
  assign out_right_reverse = right_r.reverse;

endmodule

`default_nettype wire

// File: hdl/pidd_drive.sv
`timescale 1ns / 1ps
`default_nettype none

module pidd_drive
  import pidd_pkg::*;
#(
  parameter int DRV_W = 40
) (
  input  wire logic signed [DRV_W-1:0] drive,
  input  wire logic [DUTY_W-1:0]       duty_limit,
  output drive_out_t                   result
);

  logic [DRV_W-1:0] mag;
  logic [DRV_W-1:0] limit_ext;

  // reverse follows the unclamped sign, only the magnitude is clamped
  assign mag       = drive[DRV_W-1] ? DRV_W'(-drive) : DRV_W'(drive);
  assign limit_ext = {{(DRV_W-DUTY_W){1'b0}}, duty_limit};

  always_comb begin
    result.reverse = drive[DRV_W-1];
    if (mag > limit_ext) begin
      result.duty = duty_limit;
    end else begin
      result.duty = mag[DUTY_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hdl/pidd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pidd_checker
  import pidd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [DUTY_W-1:0]     out_left_duty,
  input wire logic                  out_left_reverse,
  input wire logic [DUTY_W-1:0]     out_right_duty,
  input wire logic                  out_right_reverse,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0]        inflight_r, inflight_nxt;
  logic [DUTY_W-1:0] dlim_r;
  logic              in_fire, out_fire;

  assign in_fire      = in_valid && in_ready;
  assign out_fire     = out_valid && out_ready;
  assign inflight_nxt = inflight_r + 3'(in_fire) - 3'(out_fire);

  // in-flight sample count, and a shadow copy of the duty limit seen on the config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
      dlim_r     <= DUTY_LIMIT_RST;
    end else begin
      inflight_r <= inflight_nxt;
      if (cfg_valid && cfg_ready && (cfg_reg_t'(cfg_index) == REG_DUTY_LIMIT)) begin
        dlim_r <= cfg_data[DUTY_W-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_duty)
      && $stable(out_left_reverse) && $stable(out_right_duty) && $stable(out_right_reverse))
    else $error("result changed while stalled");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd3)
    else $error("more samples in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("result shown without a pending sample");

  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_duty <= dlim_r) && (out_right_duty <= dlim_r))
    else $error("duty above configured limit");

endmodule

bind pid_differential_drive pidd_checker u_pidd_checker (.*);

`default_nettype wire

// File: test/pid_differential_drive_tb.sv
`timescale 1ns / 1ps

module pid_differential_drive_tb;
  import pidd_pkg::*;

  localparam int POS_W = 12;
  localparam int FRAC_BITS = 8;
  localparam int POS_MAX = (1 << POS_W) - 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_LIMIT = 100000;
  localparam int STOP_NS = 8_000_000;
  localparam int PHASE_ITEMS = 175;
  // index 7 maps to no register, a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    drive_out_t left;
    drive_out_t right;
  } wheel_pair_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DUTY_W-1:0] out_left_duty;
  logic out_left_reverse;
  logic [DUTY_W-1:0] out_right_duty;
  logic out_right_reverse;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pid_differential_drive u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_duty     (out_left_duty),
    .out_left_reverse  (out_left_reverse),
    .out_right_duty    (out_right_duty),
    .out_right_reverse (out_right_reverse),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(STOP_NS);
    $display("Some tests failed");
    $finish;
  end

  // controller registers and state as the block should hold them
  int set_pos = SETPOINT_RST;
  int kp = P_GAIN_RST;
  int ki = I_GAIN_RST;
  int kd = D_GAIN_RST;
  int base_spd = BASE_SPEED_RST;
  int integ_lim = ILIM_RST;
  int duty_lim = DUTY_LIMIT_RST;
  int integ_sum = 0;
  int last_err = 0;

  logic [POS_W-1:0] sample_q[$];
  wheel_pair_t steer_q[$];
  cfg_write_t cfg_q[$];
  cfg_write_t cfg_next;
  wheel_pair_t want_pair;

  int n_queued = 0;
  int n_taken = 0;
  int n_results = 0;
  int cfg_pushed = 0;
  int cfg_done = 0;
  int n_settings = 1;
  int fail_count = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit no_idle = 1'b0;

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SETPOINT:       set_pos = data[SETPOINT_W-1:0];
      REG_P_GAIN:         kp = signed'(data);
      REG_I_GAIN:         ki = signed'(data);
      REG_D_GAIN:         kd = signed'(data);
      REG_BASE_SPEED:     base_spd = data[SPEED_W-1:0];
      REG_INTEGRAL_LIMIT: integ_lim = data[ILIM_W-1:0];
      REG_DUTY_LIMIT:     duty_lim = data[DUTY_W-1:0];
      default: ;
    endcase
  endfunction

  // flag follows the sign before the magnitude clamp
  function automatic drive_out_t wheel_cmd(longint drv);
    longint mag;
    drive_out_t w;
    mag = (drv < 0) ? -drv : drv;
    w.reverse = (drv < 0);
    if (mag > duty_lim) mag = duty_lim;
    w.duty = DUTY_W'(mag);
    return w;
  endfunction

  function automatic wheel_pair_t steer_update(logic [POS_W-1:0] pos);
    int err;
    int acc;
    int diff;
    longint mix;
    longint corr;
    wheel_pair_t res;
    err = set_pos - int'(pos);
    acc = integ_sum + err;
    if (acc > integ_lim) acc = integ_lim;
    else if (acc < -integ_lim) acc = -integ_lim;
    integ_sum = acc;
    diff = err - last_err;
    last_err = err;
    mix = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * diff;
    // signed division truncates toward zero
    corr = mix / (longint'(1) << FRAC_BITS);
    res.left = wheel_cmd(longint'(base_spd) - corr);
    res.right = wheel_cmd(longint'(base_spd) + corr);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_gain();
    if ($urandom_range(0, 1)) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 1024)) - 512;
  endfunction

  task automatic check_field(string name, logic [DUTY_W-1:0] got, logic [DUTY_W-1:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // position driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        steer_q.push_back(steer_update(in_position));
        n_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_valid <= 1'b1;
          in_position <= sample_q.pop_front();
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        cfg_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_q.size() != 0) begin
          cfg_next = cfg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= cfg_next.idx;
          cfg_data <= cfg_next.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // drive command monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (steer_q.size() == 0) begin
          $display("%0t: drive result with no sample pending, got L %0d/%0b R %0d/%0b",
                   $time, out_left_duty, out_left_reverse, out_right_duty, out_right_reverse);
          fail_count++;
        end else begin
          want_pair = steer_q.pop_front();
          check_field("left duty", out_left_duty, want_pair.left.duty);
          check_field("left reverse", out_left_reverse, want_pair.left.reverse);
          check_field("right duty", out_right_duty, want_pair.right.duty);
          check_field("right reverse", out_right_reverse, want_pair.right.reverse);
          n_results++;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  task automatic push_sample(int v);
    sample_q.push_back(POS_W'(v));
    n_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_write_t w;
    w.idx = idx;
    w.data = CFG_DATA_W'(val);
    cfg_q.push_back(w);
    cfg_pushed++;
  endtask

  task automatic write_all(int sp, int p, int i, int d, int base, int ilim, int dlim);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_P_GAIN, p);
    write_reg(REG_I_GAIN, i);
    write_reg(REG_D_GAIN, d);
    write_reg(REG_BASE_SPEED, base);
    write_reg(REG_INTEGRAL_LIMIT, ilim);
    write_reg(REG_DUTY_LIMIT, dlim);
    n_settings++;
  endtask

  task automatic commit_cfg();
    while (cfg_done != cfg_pushed) @(posedge clk);
    @(posedge clk);
  endtask

  // wait until every sample is taken and answered, then let the pipeline empty
  task automatic drain();
    int waited;
    waited = 0;
    while ((n_taken != n_queued || steer_q.size() != 0) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      $display("%0t: %0d samples untaken, %0d drive results never arrived",
               $time, n_queued - n_taken, steer_q.size());
      fail_count++;
      steer_q.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // runs of positions: uniform, near the setpoint, one side of it, or rail to rail
  task automatic queue_random(int count, int sp);
    int remaining;
    int run;
    int kind;
    int lo;
    int hi;
    remaining = count;
    while (remaining > 0) begin
      run = $urandom_range(1, 20);
      if (run > remaining) run = remaining;
      kind = $urandom_range(0, 5);
      lo = 0;
      hi = POS_MAX;
      case (kind)
        2: begin
          lo = (sp > 48) ? sp - 48 : 0;
          hi = (sp + 48 < POS_MAX) ? sp + 48 : POS_MAX;
        end
        3: lo = sp;
        4: hi = sp;
        default: ;
      endcase
      repeat (run) begin
        if (kind == 5) push_sample($urandom_range(0, 1) ? POS_MAX : 0);
        else push_sample($urandom_range(lo, hi));
        remaining--;
      end
    end
  endtask

  initial begin
    int sp;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero error, both rails, integral driven into its clamp
    push_sample(180); push_sample(0); push_sample(4095); push_sample(4095);
    push_sample(4095); push_sample(0); push_sample(2048);
    drain();

    // integral only, small limit so the clamp shows directly in the output
    write_all(2048, 0, 256, 0, 0, 100, 16383);
    commit_cfg();
    push_sample(2047); push_sample(0); push_sample(0); push_sample(4095); push_sample(4095);
    drain();

    // tiny gain: corrections of magnitude below one truncate to zero drive
    write_all(2048, 1, 0, 0, 0, 3000, 16383);
    commit_cfg();
    push_sample(2049); push_sample(2047); push_sample(2048);
    drain();

    // zero integral limit and zero duty limit, flags still follow the sign
    write_all(2048, -32768, 32767, 32767, 5000, 0, 0);
    commit_cfg();
    push_sample(0); push_sample(4095); push_sample(2048);
    drain();

    write_all(4095, 32767, 32767, 32767, 16383, 32767, 16383);
    commit_cfg();
    push_sample(0); push_sample(0); push_sample(0); push_sample(4095);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          sp = 4095;
          write_all(sp, 32767, 32767, 32767, 16383, 32767, 16383);
        end
        1: begin
          sp = 0;
          write_all(sp, -32768, -32768, -32768, 0, 0, 0);
        end
        2: begin
          sp = 2048;
          write_all(sp, 1664, 20, 44, 700, 3000, 1000);
        end
        default: begin
          sp = $urandom_range(0, POS_MAX);
          write_all(sp, pick_gain(), pick_gain(), pick_gain(),
                    $urandom_range(0, 1) ? $urandom_range(0, 16383) : $urandom_range(0, 2000),
                    $urandom_range(0, 1) ? $urandom_range(0, 32767) : $urandom_range(0, 4000),
                    $urandom_range(0, 1) ? $urandom_range(0, 16383) : $urandom_range(500, 2000));
          if (ph == 3) write_reg(REG_SPARE, $urandom_range(0, 65535));
        end
      endcase
      commit_cfg();
      no_idle = (ph == 2 || ph == 5);
      queue_random(PHASE_ITEMS, sp);
      drain();
    end

    $display("checked %0d wheel commands from %0d position samples", n_results, n_taken);
    $display("over %0d gain and limit settings, extremes and zero limits included", n_settings);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
